FILE: hw/rtl/bpmb_pkg.sv
// Shared definitions for the bit packed message buffer.
// Sizes, operation codes, sequencer states, memory request type and bit helpers.
// No dependencies.
package bpmb_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int SIZE_W      = 13;
	localparam int EXT_W       = SIZE_W + 1;
	localparam int CUR_W       = SIZE_W + 3;

	typedef enum logic [3:0] {
		K_CLEAR       = 4'd0,
		K_BEGIN_READ  = 4'd1,
		K_WRITE_BITS  = 4'd2,
		K_WRITE_BIT   = 4'd3,
		K_WRITE_BYTE  = 4'd4,
		K_WRITE_SHORT = 4'd5,
		K_WRITE_LONG  = 4'd6,
		K_READ_BITS   = 4'd7,
		K_READ_BYTE   = 4'd8,
		K_READ_SHORT  = 4'd9,
		K_READ_LONG   = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WBITS,
		S_WBITS_MOD,
		S_WBYTE,
		S_RBITS,
		S_RBITS_GET,
		S_RDATA
	} state_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	function automatic logic [7:0] lo_mask(input logic [3:0] k);
		logic [8:0] m;
		m = (9'd1 << k) - 9'd1;
		lo_mask = m[7:0];
	endfunction

	// bits handled in one byte step: remaining count, capped by room left in the byte
	function automatic logic [3:0] take_bits(input logic [5:0] n, input logic [2:0] pos);
		logic [3:0] room;
		room = 4'd8 - {1'b0, pos};
		if (n < {2'b00, room}) begin
			take_bits = n[3:0];
		end else begin
			take_bits = room;
		end
	endfunction

endpackage

FILE: hw/rtl/bit_packed_message_buffer.sv
// Top level of the bit packed message buffer: capacity register, byte store, sequencer.
// Uses bpmb_pkg, bpmb_ram and bpmb_engine.
//
//   channel   handshake          fields
//   command   start / busy       kind, value, bit_count
//   result    done (one cycle)   read_value, overflowed, write_size, read_past_end
//   config    cfg_wen            cfg_wdata (capacity in bytes)
//
// Clear, begin read, spare kinds, refused writes and past-end byte reads touch no store.
// Byte, short, long: one store access per byte. Bit writes: fresh bytes are written,
// partial bytes read, then written back. Bit reads: each byte touched is read, then its
// bits taken. done rises the cycle after the last step; start may be taken then.
// Reset clears sizes, cursor and flag; store contents stay undefined.
// The result receiver cannot stall.
module bit_packed_message_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [bpmb_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                        start,
	output logic                        busy,
	input  logic [3:0]                  kind,
	input  logic signed [31:0]          value,
	input  logic [5:0]                  bit_count,
	output logic                        done,
	output logic signed [31:0]          read_value,
	output logic                        overflowed,
	output logic [bpmb_pkg::SIZE_W-1:0] write_size,
	output logic                        read_past_end
);

	import bpmb_pkg::*;

	logic [SIZE_W-1:0] capacity_q;
	logic [SIZE_W-1:0] usable;
	mem_req_t          mem_req;
	logic [7:0]        mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= SIZE_W'(4096);
		end else if (cfg_wen) begin
			capacity_q <= cfg_wdata;
		end
	end

	assign usable = (capacity_q > SIZE_W'(STORE_BYTES)) ? SIZE_W'(STORE_BYTES) : capacity_q;

	bpmb_ram #(
		.DEPTH (STORE_BYTES),
		.WIDTH (8)
	) u_store (
		.clk   (clk),
		.en    (mem_req.en),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	bpmb_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.usable        (usable),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.value         (value),
		.bit_count     (bit_count),
		.done          (done),
		.read_value    (read_value),
		.overflowed    (overflowed),
		.write_size    (write_size),
		.read_past_end (read_past_end),
		.mem_req       (mem_req),
		.mem_rdata     (mem_rdata)
	);

endmodule

FILE: hw/rtl/bpmb_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bpmb_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: hw/rtl/bpmb_engine.sv
// Sequencer and state registers of the message buffer.
// Walks each item byte by byte through the byte store port; uses bpmb_pkg.
module bpmb_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [bpmb_pkg::SIZE_W-1:0] usable,
	input  logic                     start,
	output logic                     busy,
	input  logic [3:0]               kind,
	input  logic signed [31:0]       value,
	input  logic [5:0]               bit_count,
	output logic                     done,
	output logic signed [31:0]       read_value,
	output logic                     overflowed,
	output logic [bpmb_pkg::SIZE_W-1:0] write_size,
	output logic                     read_past_end,
	output bpmb_pkg::mem_req_t       mem_req,
	input  logic [7:0]               mem_rdata
);

	import bpmb_pkg::*;

	state_t state_q, state_d;
	logic done_q, done_d;
	logic ov_q, ov_d;
	logic [SIZE_W-1:0] wb_q, wb_d, rp_q, rp_d;
	logic [CUR_W-1:0] cur_q, cur_d;
	logic [31:0] val_q, val_d, acc_q, acc_d, res_q, res_d;
	logic [5:0] n_q, n_d, i_q, i_d;
	logic [2:0] bcnt_q, bcnt_d;
	logic [1:0] bidx_q, bidx_d;
	kind_t kind_q, kind_d;

	logic [2:0] pos;
	logic [3:0] k;
	logic [SIZE_W-1:0] at;
	logic [SIZE_W-1:0] raddr_next;
	logic [2:0] nb;
	logic [5:0] count_sat;
	logic [7:0] bits;
	logic [31:0] word;
	logic fit_bits, fit_one, fit_bytes, past_bytes;

	always_comb begin
		case (kind_t'(kind))
			K_WRITE_BYTE, K_READ_BYTE:   nb = 3'd1;
			K_WRITE_SHORT, K_READ_SHORT: nb = 3'd2;
			K_WRITE_LONG, K_READ_LONG:   nb = 3'd4;
			default:                     nb = 3'd0;
		endcase
	end

	assign count_sat  = (bit_count > 6'd32) ? 6'd32 : bit_count;
	assign fit_bits   = ({1'b0, wb_q} + EXT_W'(4)) <= {1'b0, usable};
	assign fit_one    = ({1'b0, wb_q} + EXT_W'(1)) <= {1'b0, usable};
	assign fit_bytes  = ({1'b0, wb_q} + EXT_W'(nb)) <= {1'b0, usable};
	assign past_bytes = ({1'b0, rp_q} + EXT_W'(nb)) > {1'b0, wb_q};

	assign pos        = cur_q[2:0];
	assign k          = take_bits(n_q, pos);
	assign at         = cur_q[CUR_W-1:3];
	assign raddr_next = rp_q + SIZE_W'(bidx_q) + SIZE_W'(1);
	assign bits       = (mem_rdata >> pos) & lo_mask(k);
	assign word       = acc_q | (32'(mem_rdata) << {bidx_q, 3'b000});

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		ov_d    = ov_q;
		wb_d    = wb_q;
		rp_d    = rp_q;
		cur_d   = cur_q;
		val_d   = val_q;
		acc_d   = acc_q;
		res_d   = res_q;
		n_d     = n_q;
		i_d     = i_q;
		bcnt_d  = bcnt_q;
		bidx_d  = bidx_q;
		kind_d  = kind_q;
		mem_req = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_d = kind_t'(kind);
					val_d  = value;
					n_d    = count_sat;
					acc_d  = '0;
					i_d    = '0;
					bidx_d = '0;
					bcnt_d = nb;
					res_d  = '0;
					case (kind_t'(kind))
						K_CLEAR: begin
							wb_d   = '0;
							rp_d   = '0;
							cur_d  = '0;
							ov_d   = 1'b0;
							done_d = 1'b1;
						end
						K_BEGIN_READ: begin
							rp_d   = '0;
							cur_d  = '0;
							done_d = 1'b1;
						end
						K_WRITE_BITS: begin
							if (!fit_bits) begin
								ov_d   = 1'b1;
								done_d = 1'b1;
							end else begin
								state_d = S_WBITS;
							end
						end
						K_WRITE_BIT: begin
							n_d = 6'd1;
							if (!fit_one) begin
								ov_d   = 1'b1;
								done_d = 1'b1;
							end else begin
								state_d = S_WBITS;
							end
						end
						K_WRITE_BYTE, K_WRITE_SHORT, K_WRITE_LONG: begin
							if (!fit_bytes) begin
								ov_d   = 1'b1;
								done_d = 1'b1;
							end else begin
								state_d = S_WBYTE;
							end
						end
						K_READ_BITS: begin
							state_d = S_RBITS;
						end
						K_READ_BYTE, K_READ_SHORT, K_READ_LONG: begin
							if (past_bytes) begin
								res_d  = '1;
								done_d = 1'b1;
							end else begin
								mem_req.en   = 1'b1;
								mem_req.addr = rp_q[ADDR_W-1:0];
								state_d      = S_RDATA;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_WBITS: begin
				if (n_q == 6'd0) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (pos == 3'd0) begin
					// fresh byte at the write size, zeroed then filled
					mem_req.en    = wb_q < SIZE_W'(STORE_BYTES);
					mem_req.we    = 1'b1;
					mem_req.addr  = wb_q[ADDR_W-1:0];
					mem_req.wdata = val_q[7:0] & lo_mask(k);
					cur_d = {wb_q, 3'b000} + CUR_W'(k);
					wb_d  = wb_q + SIZE_W'(1);
					val_d = val_q >> k;
					n_d   = n_q - 6'(k);
				end else begin
					mem_req.en   = 1'b1;
					mem_req.addr = at[ADDR_W-1:0];
					state_d      = S_WBITS_MOD;
				end
			end
			S_WBITS_MOD: begin
				mem_req.en    = at < SIZE_W'(STORE_BYTES);
				mem_req.we    = 1'b1;
				mem_req.addr  = at[ADDR_W-1:0];
				mem_req.wdata = mem_rdata | ((val_q[7:0] & lo_mask(k)) << pos);
				cur_d   = cur_q + CUR_W'(k);
				val_d   = val_q >> k;
				n_d     = n_q - 6'(k);
				state_d = S_WBITS;
			end
			S_WBYTE: begin
				mem_req.en    = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.addr  = wb_q[ADDR_W-1:0];
				mem_req.wdata = val_q[7:0];
				wb_d   = wb_q + SIZE_W'(1);
				val_d  = val_q >> 8;
				bcnt_d = bcnt_q - 3'd1;
				if (bcnt_q == 3'd1) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RBITS: begin
				if (n_q == 6'd0) begin
					res_d   = acc_q;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if ((pos == 3'd0 && rp_q >= wb_q) || (pos != 3'd0 && at >= wb_q)) begin
					// ran off the written bytes: gathered bits are dropped
					rp_d    = wb_q + SIZE_W'(1);
					res_d   = '0;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (pos == 3'd0) begin
					mem_req.en   = 1'b1;
					mem_req.addr = rp_q[ADDR_W-1:0];
					cur_d        = {rp_q, 3'b000};
					rp_d         = rp_q + SIZE_W'(1);
					state_d      = S_RBITS_GET;
				end else begin
					mem_req.en   = 1'b1;
					mem_req.addr = at[ADDR_W-1:0];
					state_d      = S_RBITS_GET;
				end
			end
			S_RBITS_GET: begin
				acc_d   = acc_q | (32'(bits) << i_q[4:0]);
				i_d     = i_q + 6'(k);
				cur_d   = cur_q + CUR_W'(k);
				n_d     = n_q - 6'(k);
				state_d = S_RBITS;
			end
			S_RDATA: begin
				if ((3'(bidx_q) + 3'd1) == bcnt_q) begin
					rp_d    = rp_q + SIZE_W'(bcnt_q);
					res_d   = (kind_q == K_READ_SHORT) ? {{16{word[15]}}, word[15:0]} : word;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					acc_d        = word;
					bidx_d       = bidx_q + 2'd1;
					mem_req.en   = 1'b1;
					mem_req.addr = raddr_next[ADDR_W-1:0];
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			ov_q    <= 1'b0;
			wb_q    <= '0;
			rp_q    <= '0;
			cur_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			ov_q    <= ov_d;
			wb_q    <= wb_d;
			rp_q    <= rp_d;
			cur_q   <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q  <= val_d;
		acc_q  <= acc_d;
		res_q  <= res_d;
		n_q    <= n_d;
		i_q    <= i_d;
		bcnt_q <= bcnt_d;
		bidx_q <= bidx_d;
		kind_q <= kind_d;
	end

	assign busy          = state_q != S_IDLE;
	assign done          = done_q;
	assign read_value    = res_q;
	assign overflowed    = ov_q;
	assign write_size    = wb_q;
	assign read_past_end = rp_q > wb_q;

endmodule
